[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL of the noise channel.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define NCLE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define NCLE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/ncle_pkg.sv]
// Types and constants of the noise channel.
`timescale 1ns / 1ps

package ncle_pkg;

   // Operation carried by one input beat.
   typedef enum logic [2:0] {
      FUNC_DIV_TICK = 3'd0,
      FUNC_LEN_TICK = 3'd1,
      FUNC_ENV_TICK = 3'd2,
      FUNC_WRITE    = 3'd3,
      FUNC_READ     = 3'd4
   } func_type;

   // Register selected by write and read beats.
   typedef enum logic [1:0] {
      REG_LENGTH   = 2'd0,
      REG_ENVELOPE = 2'd1,
      REG_FREQ     = 2'd2,
      REG_CONTROL  = 2'd3
   } reg_type;

   localparam int DIV_W       = 22;
   localparam int LFSR_W      = 15;
   localparam int MAG_W       = 14;
   localparam int SAMPLE_W    = 15;
   localparam int SAMPLE_STEP = 600;
   localparam logic [7:0] DAC_MASK = 8'hF8;
   localparam logic [3:0] VOL_MAX  = 4'd15;
   localparam logic [6:0] BASE_DIV_ZERO = 7'd8;

endpackage

[rtl/core/noise_channel_lfsr_envelope_unit.sv]
// Top level of the noise sound channel: divider, LFSR, length, envelope, registers.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel   Direction  Content
// req_*     in         tuser: func, reg_index; tdata: write_data
// rsp_*     out        tdata: read_data, audio_sample, channel_on
//
// One beat is accepted per cycle while req_tready is high; its result is held in the output register
// and shows on rsp_* in the cycle after acceptance.
// All channel state is updated in the same cycle by one pass of next-state logic;
// the path is set by the divider period compare and the volume times 600 product.
// A stalled result holds the output register; req_tready stays high while the
// register is empty or being drained, so the input never waits on an idle output.
// Synchronous reset clears all channel state and drops rsp_tvalid.
module noise_channel_lfsr_envelope_unit #(
   parameter int LENGTH_MAX = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] write_data
   input  logic [4:0]  req_tuser,   // [2:0] func, [4:3] reg_index
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [7:0] read_data, [22:8] audio_sample, [23] channel_on
);

   // Length counter must hold both the limit and any 6-bit reload value.
   localparam int LEN_W = (LENGTH_MAX > 63) ? $clog2(LENGTH_MAX + 1) : 6;
   localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LENGTH_MAX);

   ncle_pkg::func_type req_func;
   ncle_pkg::reg_type  req_reg;
   logic               req_fire;

   logic [ncle_pkg::DIV_W-1:0]  divider_count_ff, divider_count_in;
   logic [ncle_pkg::LFSR_W-1:0] shift_reg_ff, shift_reg_in;
   logic                        out_bit_ff, out_bit_in;
   logic [LEN_W-1:0]            length_count_ff, length_count_in;
   logic [5:0]                  length_reload_ff, length_reload_in;
   logic [3:0]                  start_volume_ff, start_volume_in;
   logic [3:0]                  volume_now_ff, volume_now_in;
   logic                        env_up_ff, env_up_in;
   logic [2:0]                  env_pace_ff, env_pace_in;
   logic [3:0]                  env_count_ff, env_count_in;
   logic                        dac_on_ff, dac_on_in;
   logic                        active_ff, active_in;
   logic [2:0]                  div_code_ff, div_code_in;
   logic                        short_mode_ff, short_mode_in;
   logic [3:0]                  shift_amount_ff, shift_amount_in;
   logic                        length_enable_ff, length_enable_in;
   logic                        trigger_bit_ff, trigger_bit_in;

   logic                        rsp_valid_ff;
   logic [7:0]                  read_data_ff, read_data_in;
   logic [ncle_pkg::SAMPLE_W-1:0] sample_ff, sample_in;
   logic                        channel_on_ff;

   logic [ncle_pkg::MAG_W-1:0]  sample_mag;

   assign req_func   = ncle_pkg::func_type'(req_tuser[2:0]);
   assign req_reg    = ncle_pkg::reg_type'(req_tuser[4:3]);
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   // Next channel state for the beat on the input.
   always_comb begin
      logic [6:0]                  base;
      logic [ncle_pkg::DIV_W-1:0]  period;
      logic [ncle_pkg::DIV_W-1:0]  count_inc;
      logic [ncle_pkg::LFSR_W-1:0] lfsr_next;
      logic                        feedback;
      logic [LEN_W-1:0]            len_next;
      logic [3:0]                  env_next;

      divider_count_in = divider_count_ff;
      shift_reg_in     = shift_reg_ff;
      out_bit_in       = out_bit_ff;
      length_count_in  = length_count_ff;
      length_reload_in = length_reload_ff;
      start_volume_in  = start_volume_ff;
      volume_now_in    = volume_now_ff;
      env_up_in        = env_up_ff;
      env_pace_in      = env_pace_ff;
      env_count_in     = env_count_ff;
      dac_on_in        = dac_on_ff;
      active_in        = active_ff;
      div_code_in      = div_code_ff;
      short_mode_in    = short_mode_ff;
      shift_amount_in  = shift_amount_ff;
      length_enable_in = length_enable_ff;
      trigger_bit_in   = trigger_bit_ff;
      read_data_in     = 8'd0;

      base      = (div_code_ff != 3'd0) ? {div_code_ff, 4'b0000} : ncle_pkg::BASE_DIV_ZERO;
      period    = ncle_pkg::DIV_W'(base) << shift_amount_ff;
      count_inc = divider_count_ff + ncle_pkg::DIV_W'(1);

      // XNOR feedback enters at the top, and also at bit 6 in short mode.
      feedback  = ~(shift_reg_ff[0] ^ shift_reg_ff[1]);
      lfsr_next = {feedback, shift_reg_ff[ncle_pkg::LFSR_W-1:1]};
      if (short_mode_ff) begin
         lfsr_next[6] = feedback;
      end

      len_next = (length_count_ff < LEN_LIMIT) ? length_count_ff + LEN_W'(1) : length_count_ff;
      env_next = env_count_ff + 4'd1;

      unique case (req_func)
         ncle_pkg::FUNC_DIV_TICK: begin
            if (count_inc >= period) begin
               divider_count_in = '0;
               shift_reg_in     = lfsr_next;
               out_bit_in       = lfsr_next[0];
            end else begin
               divider_count_in = count_inc;
            end
         end
         ncle_pkg::FUNC_LEN_TICK: begin
            if (length_enable_ff) begin
               length_count_in = len_next;
               if (len_next >= LEN_LIMIT) begin
                  active_in = 1'b0;
               end
            end
         end
         ncle_pkg::FUNC_ENV_TICK: begin
            if (env_pace_ff != 3'd0) begin
               env_count_in = env_next;
               if (env_next >= {1'b0, env_pace_ff}) begin
                  env_count_in = 4'd0;
                  if (env_up_ff) begin
                     if (volume_now_ff < ncle_pkg::VOL_MAX) begin
                        volume_now_in = volume_now_ff + 4'd1;
                     end
                  end else if (volume_now_ff != 4'd0) begin
                     volume_now_in = volume_now_ff - 4'd1;
                  end
               end
            end
         end
         ncle_pkg::FUNC_WRITE: begin
            unique case (req_reg)
               ncle_pkg::REG_LENGTH: begin
                  length_reload_in = req_tdata[5:0];
               end
               ncle_pkg::REG_ENVELOPE: begin
                  start_volume_in = req_tdata[7:4];
                  env_up_in       = req_tdata[3];
                  env_pace_in     = req_tdata[2:0];
                  env_count_in    = {1'b0, req_tdata[2:0]};
                  dac_on_in       = (req_tdata & ncle_pkg::DAC_MASK) != 8'd0;
                  if (!dac_on_in) begin
                     active_in = 1'b0;
                  end
               end
               ncle_pkg::REG_FREQ: begin
                  div_code_in     = req_tdata[2:0];
                  short_mode_in   = req_tdata[3];
                  shift_amount_in = req_tdata[7:4];
               end
               ncle_pkg::REG_CONTROL: begin
                  length_enable_in = req_tdata[6];
                  trigger_bit_in   = req_tdata[7];
                  if (req_tdata[6] && (length_count_ff >= LEN_LIMIT)) begin
                     active_in = 1'b0;
                  end
                  // Trigger: restart the channel, or drop it when the DAC is off.
                  if (req_tdata[7]) begin
                     if (!dac_on_ff) begin
                        active_in = 1'b0;
                     end else begin
                        if (length_count_ff >= LEN_LIMIT) begin
                           length_count_in = LEN_W'(length_reload_ff);
                        end
                        active_in     = 1'b1;
                        env_count_in  = 4'd0;
                        volume_now_in = start_volume_ff;
                        shift_reg_in  = '0;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         ncle_pkg::FUNC_READ: begin
            unique case (req_reg)
               ncle_pkg::REG_LENGTH:   read_data_in = 8'd0;
               ncle_pkg::REG_ENVELOPE: read_data_in = {start_volume_ff, env_up_ff, env_pace_ff};
               ncle_pkg::REG_FREQ:     read_data_in = {shift_amount_ff, short_mode_ff,
                                                      div_code_ff};
               ncle_pkg::REG_CONTROL:  read_data_in = {trigger_bit_ff, length_enable_ff, 6'd0};
               default:                read_data_in = 8'd0;
            endcase
         end
         default: begin
            // Unknown operation: leave all state as it is.
         end
      endcase
   end

   // Sample from the state after this beat: silent when the DAC or channel is off.
   assign sample_mag = ncle_pkg::MAG_W'({10'd0, volume_now_in} *
                                        ncle_pkg::MAG_W'(ncle_pkg::SAMPLE_STEP));

   always_comb begin
      if (!dac_on_in || !active_in) begin
         sample_in = '0;
      end else if (out_bit_in) begin
         sample_in = {1'b0, sample_mag};
      end else begin
         sample_in = ncle_pkg::SAMPLE_W'(0) - {1'b0, sample_mag};
      end
   end

   // Advance the channel state on every accepted beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         divider_count_ff <= '0;
         shift_reg_ff     <= '0;
         out_bit_ff       <= 1'b0;
         length_count_ff  <= '0;
         length_reload_ff <= '0;
         start_volume_ff  <= '0;
         volume_now_ff    <= '0;
         env_up_ff        <= 1'b0;
         env_pace_ff      <= '0;
         env_count_ff     <= '0;
         dac_on_ff        <= 1'b0;
         active_ff        <= 1'b0;
         div_code_ff      <= '0;
         short_mode_ff    <= 1'b0;
         shift_amount_ff  <= '0;
         length_enable_ff <= 1'b0;
         trigger_bit_ff   <= 1'b0;
      end else if (req_fire) begin
         divider_count_ff <= divider_count_in;
         shift_reg_ff     <= shift_reg_in;
         out_bit_ff       <= out_bit_in;
         length_count_ff  <= length_count_in;
         length_reload_ff <= length_reload_in;
         start_volume_ff  <= start_volume_in;
         volume_now_ff    <= volume_now_in;
         env_up_ff        <= env_up_in;
         env_pace_ff      <= env_pace_in;
         env_count_ff     <= env_count_in;
         dac_on_ff        <= dac_on_in;
         active_ff        <= active_in;
         div_code_ff      <= div_code_in;
         short_mode_ff    <= short_mode_in;
         shift_amount_ff  <= shift_amount_in;
         length_enable_ff <= length_enable_in;
         trigger_bit_ff   <= trigger_bit_in;
      end
   end

   // Output register: load on accept, drop valid once the beat is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         read_data_ff  <= read_data_in;
         sample_ff     <= sample_in;
         channel_on_ff <= active_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {channel_on_ff, sample_ff, read_data_ff};

   `NCLE_ASSERT(a_active_needs_dac, clock, reset, active_ff |-> dac_on_ff, "channel active with DAC off")
   `NCLE_ASSERT(a_sample_needs_on, clock, reset, (rsp_tvalid && (rsp_tdata[22:8] != 15'd0)) |-> rsp_tdata[23], "nonzero sample while channel off")
   `NCLE_ASSERT(a_accept_gives_rsp, clock, reset, req_fire |=> rsp_tvalid, "accepted beat gave no result")
   `NCLE_ASSERT(a_read_data_only_read, clock, reset, (req_fire && (req_func != ncle_pkg::FUNC_READ)) |=> (rsp_tdata[7:0] == 8'd0), "read data on a non-read beat")

endmodule

[sim/noise_channel_checker.sv]
// Predicts every result beat of the noise channel and compares it with the result stream.
`timescale 1ns / 1ps

module noise_channel_checker #(
   parameter int LENGTH_MAX = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] write_data
   input  logic [4:0]  req_tuser,   // [2:0] func, [4:3] reg_index
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,   // [7:0] read_data, [22:8] audio_sample, [23] channel_on
   output int          error_count,
   output int          pending_count
);
   import ncle_pkg::*;

   typedef struct packed {
      logic [7:0]  rd;
      logic [14:0] level;
      logic        on;
   } chan_out_t;

   chan_out_t pending_outputs[$];

   // Shadow copy of the channel state.
   logic [21:0] div_cnt;
   logic [14:0] lfsr;
   logic        noise_bit;
   logic [6:0]  len_cnt;
   logic [5:0]  len_reload;
   logic [3:0]  vol_init;
   logic [3:0]  vol;
   logic        env_dir;
   logic [2:0]  env_period;
   logic [3:0]  env_timer;
   logic        dac_en;
   logic        chan_active;
   logic [2:0]  div_sel;
   logic        narrow;
   logic [3:0]  clk_shift;
   logic        len_en;
   logic        trig_flag;

   // Feedback enters at bit 15 (and bit 7 in narrow mode) of a 16-bit view, then shift.
   function automatic void shift_noise();
      logic [15:0] v;
      logic        fb;
      v = {1'b0, lfsr};
      fb = ~(v[0] ^ v[1]);
      v[15] = fb;
      if (narrow) v[7] = fb;
      v = v >> 1;
      lfsr = v[14:0];
      noise_bit = v[0];
   endfunction

   function automatic void divider_tick();
      int unsigned period;
      period = (div_sel != 3'd0) ? div_sel * 16 : int'(BASE_DIV_ZERO);
      period = period << clk_shift;
      div_cnt = div_cnt + 22'd1;
      if (div_cnt >= period) begin
         div_cnt = '0;
         shift_noise();
      end
   endfunction

   function automatic void length_tick();
      if (len_en) begin
         if (len_cnt < LENGTH_MAX) len_cnt = len_cnt + 7'd1;
         if (len_cnt >= LENGTH_MAX) chan_active = 1'b0;
      end
   endfunction

   function automatic void envelope_tick();
      if (env_period != 3'd0) begin
         env_timer = env_timer + 4'd1;
         if (env_timer >= env_period) begin
            env_timer = '0;
            if (env_dir) begin
               if (vol < VOL_MAX) vol = vol + 4'd1;
            end else if (vol > 4'd0) begin
               vol = vol - 4'd1;
            end
         end
      end
   endfunction

   function automatic void trigger_note();
      if (!dac_en) begin
         chan_active = 1'b0;
      end else begin
         if (len_cnt >= LENGTH_MAX) len_cnt = {1'b0, len_reload};
         chan_active = 1'b1;
         env_timer = '0;
         vol = vol_init;
         lfsr = '0;
      end
   endfunction

   function automatic void write_reg(logic [1:0] sel, logic [7:0] d);
      case (sel)
         REG_LENGTH: len_reload = d[5:0];
         REG_ENVELOPE: begin
            vol_init = d[7:4];
            env_dir = d[3];
            env_period = d[2:0];
            env_timer = {1'b0, d[2:0]};
            dac_en = |(d & DAC_MASK);
            if (!dac_en) chan_active = 1'b0;
         end
         REG_FREQ: begin
            div_sel = d[2:0];
            narrow = d[3];
            clk_shift = d[7:4];
         end
         default: begin
            len_en = d[6];
            if (len_en && len_cnt >= LENGTH_MAX) chan_active = 1'b0;
            trig_flag = d[7];
            if (trig_flag) trigger_note();
         end
      endcase
   endfunction

   function automatic logic [7:0] read_reg(logic [1:0] sel);
      case (sel)
         REG_LENGTH:   return 8'd0;
         REG_ENVELOPE: return {vol_init, env_dir, env_period};
         REG_FREQ:     return {clk_shift, narrow, div_sel};
         default:      return {trig_flag, len_en, 6'd0};
      endcase
   endfunction

   // Apply one beat to the shadow state and return the result it must produce.
   function automatic chan_out_t predict_channel(logic [2:0] op, logic [1:0] sel,
                                                 logic [7:0] d);
      chan_out_t   r;
      logic [14:0] mag;
      r = '0;
      case (op)
         FUNC_DIV_TICK: divider_tick();
         FUNC_LEN_TICK: length_tick();
         FUNC_ENV_TICK: envelope_tick();
         FUNC_WRITE:    write_reg(sel, d);
         FUNC_READ:     r.rd = read_reg(sel);
         default: ;
      endcase
      mag = 15'(vol * SAMPLE_STEP);
      if (dac_en && chan_active) r.level = noise_bit ? mag : 15'd0 - mag;
      r.on = chan_active;
      return r;
   endfunction

   always @(posedge clock) begin
      chan_out_t want;
      chan_out_t got;
      if (reset) begin
         div_cnt = '0; lfsr = '0; noise_bit = 1'b0;
         len_cnt = '0; len_reload = '0;
         vol_init = '0; vol = '0; env_dir = 1'b0; env_period = '0; env_timer = '0;
         dac_en = 1'b0; chan_active = 1'b0;
         div_sel = '0; narrow = 1'b0; clk_shift = '0;
         len_en = 1'b0; trig_flag = 1'b0;
         pending_outputs.delete();
      end else begin
         // Check the result first: a beat's own result may not show at its acceptance edge.
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[7:0], rsp_tdata[22:8], rsp_tdata[23]};
            if (pending_outputs.size() == 0) begin
               error_count = error_count + 1;
               $display("%0t: unexpected result beat: expected none, got %06h",
                        $time, rsp_tdata);
            end else begin
               want = pending_outputs.pop_front();
               if (got.rd !== want.rd) begin
                  error_count = error_count + 1;
                  $display("%0t: read_data expected %02h got %02h", $time, want.rd, got.rd);
               end
               if (got.level !== want.level) begin
                  error_count = error_count + 1;
                  $display("%0t: audio_sample expected %0d got %0d", $time,
                           $signed(want.level), $signed(got.level));
               end
               if (got.on !== want.on) begin
                  error_count = error_count + 1;
                  $display("%0t: channel_on expected %0b got %0b", $time, want.on, got.on);
               end
            end
         end
         if (req_tvalid && req_tready)
            pending_outputs.push_back(predict_channel(req_tuser[2:0], req_tuser[4:3],
                                                      req_tdata));
      end
      pending_count = pending_outputs.size();
   end

endmodule

[sim/tb_noise_channel_lfsr_envelope_unit.sv]
// Testbench top of the noise channel: clock, reset, stimulus, result stalls and verdict.
`timescale 1ns / 1ps

module tb_noise_channel_lfsr_envelope_unit;
   import ncle_pkg::*;

   localparam int LENGTH_LIMIT = 64;
   localparam int RANDOM_BEATS = 1400;

   // Receiver behavior patterns, switched at random by the stall process.
   typedef enum int {
      READY_ALWAYS,
      READY_MOSTLY,
      READY_PERIODIC,
      READY_COIN
   } stall_mode_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;    // [7:0] write_data
   logic [4:0]  req_tuser = 5'd0;    // [2:0] func, [4:3] reg_index
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;           // [7:0] read_data, [22:8] audio_sample, [23] channel_on

   int          error_count;
   int          pending_count;
   int          beats_sent = 0;
   int          stall_tick = 0;
   stall_mode_t stall_mode = READY_ALWAYS;

   noise_channel_lfsr_envelope_unit #(
      .LENGTH_MAX(LENGTH_LIMIT)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   noise_channel_checker #(
      .LENGTH_MAX(LENGTH_LIMIT)
   ) chan_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   // 2 ns clock period.
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Receiver stalls: switch among the patterns at random so stalls land on every
   // kind of beat, with stretches of full throughput in between.
   always @(negedge clock) begin
      stall_tick <= stall_tick + 1;
      if (stall_tick % 50 == 0) stall_mode <= stall_mode_t'($urandom_range(0, 3));
      case (stall_mode)
         READY_ALWAYS:   rsp_tready <= 1'b1;
         READY_MOSTLY:   rsp_tready <= ($urandom_range(0, 3) != 0);
         READY_PERIODIC: rsp_tready <= (stall_tick % 4 != 3);
         default:        rsp_tready <= ($urandom_range(0, 1) == 1);
      endcase
   end

   // Present one beat at the falling edge and hold it until the block takes it.
   // Return at the falling edge after acceptance with tvalid still high, so a
   // back-to-back beat does not drop valid in between.
   task automatic send_beat(input logic [2:0] op, input logic [1:0] sel, input logic [7:0] d);
      req_tvalid <= 1'b1;
      req_tuser  <= {sel, op};
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      beats_sent++;
   endtask

   // Drop valid for some cycles; scramble the idle bus so stale content is never trusted.
   task automatic idle_for(input int cycles);
      repeat (cycles) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'($urandom);
         req_tuser  <= 5'($urandom);
         @(negedge clock);
      end
   endtask

   // Hold off the sender until every outstanding result has been drained.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
   endtask

   // Envelope byte with the DAC on most of the time.
   function automatic logic [7:0] envelope_byte();
      logic [7:0] d;
      d = 8'($urandom);
      if ($urandom_range(0, 9) != 0 && (d & DAC_MASK) == 8'd0)
         d[7:4] = 4'($urandom_range(1, 15));
      return d;
   endfunction

   // Frequency byte: short divider periods dominate so the noise register moves.
   function automatic logic [7:0] freq_byte();
      logic [3:0] sh;
      sh = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, 2)) : 4'($urandom);
      return {sh, 1'($urandom), 3'($urandom)};
   endfunction

   // Control byte: trigger set more often than not.
   function automatic logic [7:0] control_byte();
      logic [7:0] d;
      d = 8'($urandom);
      d[7] = ($urandom_range(0, 9) < 6);
      return d;
   endfunction

   // One random beat, or a short note setup: envelope, frequency, length, trigger.
   task automatic send_random_beat();
      int         pick;
      logic [1:0] sel;
      logic [7:0] d;
      pick = $urandom_range(0, 99);
      sel  = 2'($urandom);
      d    = 8'($urandom);
      if (pick < 10) begin
         send_beat(FUNC_WRITE, REG_ENVELOPE, envelope_byte());
         send_beat(FUNC_WRITE, REG_FREQ, freq_byte());
         send_beat(FUNC_WRITE, REG_LENGTH, 8'($urandom));
         send_beat(FUNC_WRITE, REG_CONTROL, control_byte());
      end else if (pick < 52) begin
         send_beat(FUNC_DIV_TICK, sel, d);
      end else if (pick < 64) begin
         send_beat(FUNC_LEN_TICK, sel, d);
      end else if (pick < 76) begin
         send_beat(FUNC_ENV_TICK, sel, d);
      end else if (pick < 84) begin
         send_beat(FUNC_READ, sel, d);
      end else if (pick < 97) begin
         case (sel)
            REG_ENVELOPE: d = envelope_byte();
            REG_FREQ:     d = freq_byte();
            REG_CONTROL:  d = control_byte();
            default: ;
         endcase
         send_beat(FUNC_WRITE, sel, d);
      end else begin
         // Undefined operation codes above the read.
         send_beat(3'(FUNC_READ) + 3'($urandom_range(1, 3)), sel, d);
      end
   endtask

   // Run limit: far above the slowest correct run.
   initial begin
      #2000000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      int  burst;
      bit  paused;
      paused = 1'b0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part: undefined operation, note setup at the extremes,
      // volume saturating upward, divider period lowered under the count,
      // length count, register reads, DAC off and a trigger without DAC,
      // and an envelope tick with pace zero.
      send_beat(3'(FUNC_READ) + 3'd3, REG_CONTROL, 8'hFF);
      send_beat(FUNC_WRITE, REG_ENVELOPE, 8'hF9);
      send_beat(FUNC_WRITE, REG_FREQ, 8'h20);
      send_beat(FUNC_WRITE, REG_LENGTH, 8'h3F);
      send_beat(FUNC_WRITE, REG_CONTROL, 8'hC0);
      send_beat(FUNC_ENV_TICK, REG_LENGTH, 8'h00);
      repeat (10) send_beat(FUNC_DIV_TICK, REG_LENGTH, 8'h00);
      send_beat(FUNC_WRITE, REG_FREQ, 8'h08);
      send_beat(FUNC_DIV_TICK, REG_CONTROL, 8'hFF);
      send_beat(FUNC_LEN_TICK, REG_LENGTH, 8'h00);
      send_beat(FUNC_READ, REG_LENGTH, 8'h00);
      send_beat(FUNC_READ, REG_ENVELOPE, 8'h00);
      send_beat(FUNC_READ, REG_FREQ, 8'h00);
      send_beat(FUNC_READ, REG_CONTROL, 8'h00);
      send_beat(FUNC_WRITE, REG_ENVELOPE, 8'h00);
      send_beat(FUNC_WRITE, REG_CONTROL, 8'h80);
      send_beat(FUNC_ENV_TICK, REG_FREQ, 8'hFF);
      drain_results();

      // Random part: bursts of random length, gaps between most of them.
      beats_sent = 0;
      while (beats_sent < RANDOM_BEATS) begin
         burst = $urandom_range(1, 40);
         repeat (burst) send_random_beat();
         if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 6));
         if (!paused && beats_sent >= RANDOM_BEATS / 2) begin
            drain_results();
            paused = 1'b1;
         end
      end

      // Drain, then keep watching for any stray result beat before the verdict.
      drain_results();
      repeat (10) @(negedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
